// ----- rtl/lprf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lprf_pkg;

	// Default size of the circular byte store.
	localparam int STORE_BYTES_DEF = 4096;

	// Result status codes.
	localparam logic [2:0] ST_STORED     = 3'd0;
	localparam logic [2:0] ST_COMMIT     = 3'd1;
	localparam logic [2:0] ST_DROP       = 3'd2;
	localparam logic [2:0] ST_READ       = 3'd3;
	localparam logic [2:0] ST_EMPTY      = 3'd4;
	localparam logic [2:0] ST_ZERO_LIMIT = 3'd5;

	// Class of an item as decided by the front end.
	typedef enum logic [1:0] {
		OP_APPEND,
		OP_APPEND_LAST,
		OP_READ
	} op_t;

	// One classified item waiting in the queue between front and back.
	typedef struct packed {
		op_t         op;
		logic [7:0]  data_byte;
		logic [15:0] read_limit;
	} item_t;

endpackage

`default_nettype wire

// ----- rtl/lprf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lprf_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              kind,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last,
	input  wire logic [15:0]       read_limit,
	output logic                   item_valid,
	output lprf_pkg::item_t        item,
	input  wire logic              item_pop
);

	// Two entries let the back end finish one item while the next waits.
	localparam int DEPTH = 2;
	localparam int PW = $clog2(DEPTH);

	lprf_pkg::item_t entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     fill_q;
	lprf_pkg::item_t incoming;
	logic            push;

	always_comb begin
		incoming.data_byte  = data_byte;
		incoming.read_limit = read_limit;
		if (kind) begin
			incoming.op = lprf_pkg::OP_READ;
		end else if (last) begin
			incoming.op = lprf_pkg::OP_APPEND_LAST;
		end else begin
			incoming.op = lprf_pkg::OP_APPEND;
		end
	end

	assign busy       = (fill_q == (PW+1)'(DEPTH));
	assign push       = start && !busy;
	assign item_valid = (fill_q != '0);
	assign item       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (item_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !item_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && item_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lprf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lprf_back #(
	parameter int STORE_BYTES = lprf_pkg::STORE_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire lprf_pkg::item_t   item,
	output logic                   item_pop,
	output logic                   done,
	output logic [2:0]             status,
	output logic [7:0]             out_byte,
	output logic                   end_of_record,
	output logic [11:0]            record_count
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int UW = $clog2(STORE_BYTES + 1);
	localparam int SW = (AW + 2 > 19) ? AW + 2 : 19;
	localparam logic [11:0] COUNT_MAX = 12'd4095;
	localparam logic [SW-1:0] HDR_BYTES = SW'(2);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EXEC    = 3'd1;
	localparam logic [2:0] S_HDR_LO  = 3'd2;
	localparam logic [2:0] S_HDR_HI  = 3'd3;
	localparam logic [2:0] S_RD_HI   = 3'd4;
	localparam logic [2:0] S_RD_DATA = 3'd5;
	localparam logic [2:0] S_RD_FIN  = 3'd6;

	// Offset into the ring; every delta added is at most the store size.
	function automatic logic [AW-1:0] wrap_add(input logic [SW-1:0] base,
		input logic [SW-1:0] delta);
		logic [SW-1:0] sum;
		sum = base + delta;
		if (sum >= SW'(STORE_BYTES)) begin
			sum = sum - SW'(STORE_BYTES);
		end
		return sum[AW-1:0];
	endfunction

	// Header plus data, rounded up to an even byte count.
	function automatic logic [17:0] padded_size(input logic [16:0] len);
		logic [17:0] sum;
		sum = 18'(len) + 18'd3;
		return {sum[17:1], 1'b0};
	endfunction

	logic [7:0]      mem [STORE_BYTES];
	logic [7:0]      rdata_q;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [7:0]      mem_wdata;
	logic [AW-1:0]   mem_raddr;

	logic [2:0]      state_q;
	lprf_pkg::item_t cur_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   tail_q;
	logic [UW-1:0]   used_q;
	logic [11:0]     count_q;
	logic [15:0]     app_len_q;
	logic            dropped_q;
	logic [15:0]     rd_pos_q;
	logic [15:0]     rd_len_q;
	logic [7:0]      len_lo_q;
	logic [15:0]     full_len_q;

	logic            done_q;
	logic [2:0]      status_q;
	logic [7:0]      out_byte_q;
	logic            eor_q;
	logic [11:0]     rec_count_q;

	logic [16:0]     new_len_c;
	logic [17:0]     need_c;
	logic [SW-1:0]   free_c;
	logic            fail_c;
	logic [17:0]     commit_need_c;
	logic [15:0]     full_len_c;
	logic [16:0]     rd_pos_next_c;
	logic [17:0]     rel_raw_c;
	logic [SW-1:0]   rel_sz_c;
	logic [15:0]     first_len_c;
	logic            is_last_c;

	assign item_pop = item_valid && (state_q == S_IDLE);

	assign new_len_c     = {1'b0, app_len_q} + 17'd1;
	assign need_c        = padded_size(new_len_c);
	assign free_c        = SW'(STORE_BYTES) - SW'(used_q);
	assign fail_c        = new_len_c[16] || (SW'(need_c) > free_c) || (count_q >= COUNT_MAX);
	assign commit_need_c = padded_size({1'b0, app_len_q});
	assign full_len_c    = {rdata_q, len_lo_q};
	assign rd_pos_next_c = {1'b0, rd_pos_q} + 17'd1;
	assign rel_raw_c     = padded_size({1'b0, full_len_q});
	assign rel_sz_c      = (SW'(rel_raw_c) > SW'(used_q)) ? SW'(used_q) : SW'(rel_raw_c);
	assign is_last_c     = (cur_q.op == lprf_pkg::OP_APPEND_LAST);

	// The read length is the smaller of record length and reader limit, at least one.
	always_comb begin
		first_len_c = (full_len_c < cur_q.read_limit) ? full_len_c : cur_q.read_limit;
		if (first_len_c == '0) begin
			first_len_c = 16'd1;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = cur_q.data_byte;
		mem_raddr = head_q;
		case (state_q)
			S_EXEC: begin
				mem_we    = (cur_q.op != lprf_pkg::OP_READ) && !dropped_q && !fail_c;
				mem_waddr = wrap_add(SW'(tail_q), SW'(app_len_q) + HDR_BYTES);
			end
			S_HDR_LO: begin
				mem_we    = 1'b1;
				mem_wdata = app_len_q[7:0];
			end
			S_HDR_HI: begin
				mem_we    = 1'b1;
				mem_waddr = wrap_add(SW'(tail_q), SW'(1));
				mem_wdata = app_len_q[15:8];
			end
			S_RD_HI: begin
				mem_raddr = wrap_add(SW'(head_q), SW'(1));
			end
			S_RD_DATA: begin
				mem_raddr = wrap_add(SW'(head_q), SW'(rd_pos_q) + HDR_BYTES);
			end
			default: begin
				mem_raddr = head_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			cur_q <= item;
		end
		if (state_q == S_RD_HI) begin
			len_lo_q <= rdata_q;
		end
		if (state_q == S_RD_DATA) begin
			full_len_q <= full_len_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			used_q      <= '0;
			count_q     <= '0;
			app_len_q   <= '0;
			dropped_q   <= 1'b0;
			rd_pos_q    <= '0;
			rd_len_q    <= '0;
			done_q      <= 1'b0;
			status_q    <= lprf_pkg::ST_STORED;
			out_byte_q  <= '0;
			eor_q       <= 1'b0;
			rec_count_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					out_byte_q  <= '0;
					eor_q       <= 1'b0;
					rec_count_q <= count_q;
					case (cur_q.op)
						lprf_pkg::OP_APPEND, lprf_pkg::OP_APPEND_LAST: begin
							if (dropped_q || fail_c) begin
								done_q   <= 1'b1;
								status_q <= lprf_pkg::ST_DROP;
								state_q  <= S_IDLE;
								if (is_last_c) begin
									dropped_q <= 1'b0;
									app_len_q <= '0;
								end else begin
									dropped_q <= 1'b1;
								end
							end else begin
								app_len_q <= new_len_c[15:0];
								if (is_last_c) begin
									state_q <= S_HDR_LO;
								end else begin
									done_q   <= 1'b1;
									status_q <= lprf_pkg::ST_STORED;
									state_q  <= S_IDLE;
								end
							end
						end
						lprf_pkg::OP_READ: begin
							if (count_q == '0) begin
								done_q   <= 1'b1;
								status_q <= lprf_pkg::ST_EMPTY;
								state_q  <= S_IDLE;
							end else if (rd_pos_q == '0 && cur_q.read_limit == '0) begin
								done_q   <= 1'b1;
								status_q <= lprf_pkg::ST_ZERO_LIMIT;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_RD_HI;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_HDR_LO: begin
					state_q <= S_HDR_HI;
				end
				S_HDR_HI: begin
					used_q      <= used_q + UW'(commit_need_c);
					tail_q      <= wrap_add(SW'(tail_q), SW'(commit_need_c));
					count_q     <= count_q + 12'd1;
					app_len_q   <= '0;
					done_q      <= 1'b1;
					status_q    <= lprf_pkg::ST_COMMIT;
					out_byte_q  <= '0;
					eor_q       <= 1'b0;
					rec_count_q <= count_q + 12'd1;
					state_q     <= S_IDLE;
				end
				S_RD_HI: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (rd_pos_q == '0) begin
						rd_len_q <= first_len_c;
					end
					state_q <= S_RD_FIN;
				end
				S_RD_FIN: begin
					done_q     <= 1'b1;
					status_q   <= lprf_pkg::ST_READ;
					out_byte_q <= rdata_q;
					state_q    <= S_IDLE;
					if (rd_pos_next_c >= {1'b0, rd_len_q}) begin
						eor_q       <= 1'b1;
						head_q      <= wrap_add(SW'(head_q), rel_sz_c);
						used_q      <= used_q - rel_sz_c[UW-1:0];
						count_q     <= count_q - 12'd1;
						rec_count_q <= count_q - 12'd1;
						rd_pos_q    <= '0;
						rd_len_q    <= '0;
					end else begin
						eor_q       <= 1'b0;
						rec_count_q <= count_q;
						rd_pos_q    <= rd_pos_next_c[15:0];
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign out_byte      = out_byte_q;
	assign end_of_record = eor_q;
	assign record_count  = rec_count_q;

endmodule

`default_nettype wire

// ----- rtl/length_prefixed_record_fifo.sv -----
// FIFO of variable-length byte records in a circular byte store of STORE_BYTES bytes. Each
// record is kept as a two-byte length header (low byte first), its data, and one pad byte
// when needed to make the size even. An item is taken when start is high and busy is low;
// a two-entry queue sits between the front end that takes items and the back end that
// executes them, so start may be given again while the back end works. Every item yields
// exactly one result, shown for one cycle with done high; the receiver cannot stall, so
// results must be captured when done is high. A stored, dropped, empty or zero-limit answer
// is registered in the execute state after the item leaves the queue; the byte that commits
// a record then passes the header-low and header-high write states (the header goes into
// the single write port one byte a cycle), and a byte read passes the read-high, read-data
// and read-finish states (header low byte, header high byte and data byte go through the
// one registered read port in turn). The back end returns to idle between items. The store
// contents need no clearing after reset, so the block takes items once reset is released.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_record_fifo #(
	parameter int STORE_BYTES = lprf_pkg::STORE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        kind,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	input  wire logic [15:0] read_limit,
	output logic             done,
	output logic [2:0]       status,
	output logic [7:0]       out_byte,
	output logic             end_of_record,
	output logic [11:0]      record_count
);

	// Classified item at the head of the queue, and its handshake to the back end.
	lprf_pkg::item_t item;
	logic            item_valid;
	logic            item_pop;

	// The front end classifies each item as a plain append, a record-ending append or a
	// read, and holds it until the back end is free.
	lprf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.data_byte  (data_byte),
		.last       (last),
		.read_limit (read_limit),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// The back end owns the byte store and the ring pointers. It writes appended bytes
	// behind the committed data, writes the header when a record ends, and pops bytes of
	// the oldest record, releasing its space when its final delivered byte goes out.
	lprf_back #(
		.STORE_BYTES (STORE_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item          (item),
		.item_pop      (item_pop),
		.done          (done),
		.status        (status),
		.out_byte      (out_byte),
		.end_of_record (end_of_record),
		.record_count  (record_count)
	);

endmodule

`default_nettype wire

// ----- rtl/lprf_check.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lprf_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        done,
	input wire logic [2:0]  status,
	input wire logic [7:0]  out_byte,
	input wire logic        end_of_record,
	input wire logic [11:0] record_count
);

	// The back end idles between items, so results never come in adjacent cycles.
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in adjacent cycles");

	a_status_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= lprf_pkg::ST_ZERO_LIMIT)
		else $error("status code out of range");

	a_no_byte_unless_read: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != lprf_pkg::ST_READ |-> out_byte == 8'd0 && !end_of_record)
		else $error("byte or end mark on a result that is no read");

	a_empty_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == lprf_pkg::ST_EMPTY |-> record_count == 12'd0)
		else $error("empty answer with records present");

	a_commit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == lprf_pkg::ST_COMMIT |-> record_count != 12'd0)
		else $error("commit left no record");

endmodule

bind length_prefixed_record_fifo lprf_check u_lprf_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.done          (done),
	.status        (status),
	.out_byte      (out_byte),
	.end_of_record (end_of_record),
	.record_count  (record_count)
);

`default_nettype wire
